[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file tld_checker.sv.
// Depends on a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/tld_pkg.sv]
// Types and constants of the terminal line discipline.
// No dependencies; used by every module of the block.
package tld_pkg;

    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;

    localparam logic [2:0] OUT_STORED  = 3'd0;
    localparam logic [2:0] OUT_ERASED  = 3'd1;
    localparam logic [2:0] OUT_BLOCKED = 3'd2;
    localparam logic [2:0] OUT_INTR    = 3'd3;
    localparam logic [2:0] OUT_FULL    = 3'd4;
    localparam logic [2:0] OUT_READ    = 3'd5;
    localparam logic [2:0] OUT_EMPTY   = 3'd6;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [2:0] CFG_CANON = 3'd0;
    localparam logic [2:0] CFG_ECHO  = 3'd1;
    localparam logic [2:0] CFG_SIG   = 3'd2;
    localparam logic [2:0] CFG_INTR  = 3'd3;
    localparam logic [2:0] CFG_EOF   = 3'd4;
    localparam logic [2:0] CFG_ERASE = 3'd5;
    localparam logic [2:0] CFG_GROUP = 3'd6;

    typedef struct packed {
        logic       canon;
        logic       echo;
        logic       sig;
        logic [7:0] intr_char;
        logic [7:0] eof_char;
        logic [7:0] erase_char;
        logic       group;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        canon: 1'b1, echo: 1'b1, sig: 1'b1,
        intr_char: 8'd3, eof_char: 8'd4, erase_char: 8'd8, group: 1'b0
    };

    typedef struct packed {
        logic [2:0] outcome;
        logic       irq;
        logic       echo_valid;
        logic [7:0] echo_char;
        logic       wake;
        logic [7:0] read_char;
        logic       line_end;
    } t_result;

    typedef struct packed {
        logic push;
        logic erase;
        logic pop;
    } t_upd;

endpackage

[hw/rtl/tld_decide.sv]
// Byte evaluation unit: checks one key byte against the control characters and
// buffer status, or serves a read, returning result fields and buffer update.
// Depends on tld_pkg.
module tld_decide (
    input  logic              i_op,
    input  logic [7:0]        i_byte,
    input  logic [7:0]        i_peek,
    input  logic              i_empty,
    input  logic              i_full,
    input  tld_pkg::t_cfg     i_cfg,
    output tld_pkg::t_result  o_res,
    output tld_pkg::t_upd     o_upd
);

    always_comb begin
        o_res = '0;
        o_upd = '0;
        if (i_op == tld_pkg::OP_READ) begin
            if (i_empty) begin
                o_res.outcome = tld_pkg::OUT_EMPTY;
            end else begin
                o_res.outcome   = tld_pkg::OUT_READ;
                o_res.read_char = i_peek;
                o_res.line_end  = i_cfg.canon &&
                                  (i_peek == tld_pkg::CH_NEWLINE || i_peek == i_cfg.eof_char);
                o_upd.pop       = 1'b1;
            end
        end else if (i_cfg.sig && i_byte == i_cfg.intr_char) begin
            o_res.outcome = tld_pkg::OUT_INTR;
            o_res.irq     = i_cfg.group;
        end else if (i_cfg.canon && i_byte == i_cfg.erase_char && !i_empty) begin
            if (i_peek != tld_pkg::CH_NEWLINE) begin
                o_res.outcome    = tld_pkg::OUT_ERASED;
                o_res.echo_valid = i_cfg.echo;
                o_res.echo_char  = i_cfg.echo ? tld_pkg::CH_BACKSPACE : 8'h00;
                o_upd.erase      = 1'b1;
            end else begin
                o_res.outcome = tld_pkg::OUT_BLOCKED;
            end
        end else if (i_full) begin
            o_res.outcome = tld_pkg::OUT_FULL;
        end else begin
            o_res.outcome    = tld_pkg::OUT_STORED;
            o_res.echo_valid = i_cfg.echo;
            o_res.echo_char  = i_cfg.echo ? i_byte : 8'h00;
            o_res.wake       = !i_cfg.canon || i_byte == tld_pkg::CH_NEWLINE;
            o_upd.push       = 1'b1;
        end
    end

endmodule

[hw/rtl/terminal_line_discipline.sv]
// Terminal line discipline: per byte, the FETCH state reads the line store
// and the EXEC state evaluates and writes back; EXEC holds while the output
// is stalled. A key item makes one FETCH/EXEC pass per nonzero byte, a read
// item one pass; the result is registered after the store read in FETCH.
// Synchronous active-low reset restores state, config, pointers, fill count
// and out valid; empties the buffer; store stays undefined, no clearing pass.
module terminal_line_discipline #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [15:0] i_key_code,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_outcome,
    output logic        o_interrupt_request,
    output logic        o_echo_valid,
    output logic [7:0]  o_echo_char,
    output logic        o_wake_readers,
    output logic [7:0]  o_read_char,
    output logic        o_line_end,
    output logic        o_last
);

    localparam int PW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam logic [PW-1:0] PTR_MAX = PW'(BUFFER_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(BUFFER_DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [7:0] r_mem [BUFFER_DEPTH];

    logic [1:0]       r_state, n_state;
    tld_pkg::t_cfg    r_cfg;
    logic [PW-1:0]    r_rp, r_wp;
    logic [CW-1:0]    r_fill;
    logic             r_op, n_op;
    logic [7:0]       r_cur, n_cur;
    logic [7:0]       r_pend, n_pend;
    logic [7:0]       r_rdata;
    logic             r_out_valid;
    tld_pkg::t_result r_out;
    logic             r_out_last;

    logic [PW-1:0]    wp_prev, rd_addr;
    logic             fire;
    tld_pkg::t_result res;
    tld_pkg::t_upd    upd;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign wp_prev = (r_wp == '0) ? PTR_MAX : r_wp - PW'(1);
    assign rd_addr = (r_op == tld_pkg::OP_READ) ? r_rp : wp_prev;
    assign fire    = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    tld_decide u_decide (
        .i_op    (r_op),
        .i_byte  (r_cur),
        .i_peek  (r_rdata),
        .i_empty (r_fill == '0),
        .i_full  (r_fill == CNT_FULL),
        .i_cfg   (r_cfg),
        .o_res   (res),
        .o_upd   (upd)
    );

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_cur   = r_cur;
        n_pend  = r_pend;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op = i_opcode;
                    if (i_opcode == tld_pkg::OP_READ) begin
                        n_pend  = 8'h00;
                        n_state = S_FETCH;
                    end else if (i_key_code[15:8] != 8'h00) begin
                        n_cur   = i_key_code[15:8];
                        n_pend  = i_key_code[7:0];
                        n_state = S_FETCH;
                    end else if (i_key_code[7:0] != 8'h00) begin
                        n_cur   = i_key_code[7:0];
                        n_pend  = 8'h00;
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: n_state = S_EXEC;
            S_EXEC: begin
                if (fire) begin
                    if (r_pend != 8'h00) begin
                        n_cur   = r_pend;
                        n_pend  = 8'h00;
                        n_state = S_FETCH;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FETCH) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && upd.push) begin
            r_mem[r_wp] <= r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_cur  <= n_cur;
        r_pend <= n_pend;
        if (fire) begin
            r_out      <= res;
            r_out_last <= (r_op == tld_pkg::OP_READ) || (r_pend == 8'h00);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= tld_pkg::CFG_RESET;
            r_rp        <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (fire && upd.push) begin
                r_wp   <= (r_wp == PTR_MAX) ? '0 : r_wp + PW'(1);
                r_fill <= r_fill + CW'(1);
            end
            if (fire && upd.erase) begin
                r_wp   <= wp_prev;
                r_fill <= r_fill - CW'(1);
            end
            if (fire && upd.pop) begin
                r_rp   <= (r_rp == PTR_MAX) ? '0 : r_rp + PW'(1);
                r_fill <= r_fill - CW'(1);
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    tld_pkg::CFG_CANON: r_cfg.canon      <= i_cfg_data[0];
                    tld_pkg::CFG_ECHO:  r_cfg.echo       <= i_cfg_data[0];
                    tld_pkg::CFG_SIG:   r_cfg.sig        <= i_cfg_data[0];
                    tld_pkg::CFG_INTR:  r_cfg.intr_char  <= i_cfg_data;
                    tld_pkg::CFG_EOF:   r_cfg.eof_char   <= i_cfg_data;
                    tld_pkg::CFG_ERASE: r_cfg.erase_char <= i_cfg_data;
                    tld_pkg::CFG_GROUP: r_cfg.group      <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_outcome           = r_out.outcome;
    assign o_interrupt_request = r_out.irq;
    assign o_echo_valid        = r_out.echo_valid;
    assign o_echo_char         = r_out.echo_char;
    assign o_wake_readers      = r_out.wake;
    assign o_read_char         = r_out.read_char;
    assign o_line_end          = r_out.line_end;
    assign o_last              = r_out_last;

endmodule

[hw/rtl/tld_checker.sv]
// Port-level checker for the terminal line discipline, bound to the top level.
// Depends on tld_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tld_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       i_opcode,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_outcome,
    input logic       o_interrupt_request,
    input logic       o_echo_valid,
    input logic       o_wake_readers,
    input logic [7:0] o_read_char,
    input logic       o_line_end
);

    `ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_outcome))
    `ASSERT_NEXT(a_read_busy, i_in_valid && !o_in_stall && i_opcode, o_in_stall)
    `ASSERT_IMPL(a_read_fields, o_out_valid && o_outcome != tld_pkg::OUT_READ, o_read_char == 8'h00 && !o_line_end)
    `ASSERT_IMPL(a_irq_outcome, o_out_valid && o_interrupt_request, o_outcome == tld_pkg::OUT_INTR)
    `ASSERT_IMPL(a_intr_quiet, o_out_valid && o_outcome == tld_pkg::OUT_INTR, !o_echo_valid && !o_wake_readers)

endmodule

bind terminal_line_discipline tld_checker u_tld_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in_valid),
    .o_in_stall          (o_in_stall),
    .i_opcode            (i_opcode),
    .o_out_valid         (o_out_valid),
    .i_out_stall         (i_out_stall),
    .o_outcome           (o_outcome),
    .o_interrupt_request (o_interrupt_request),
    .o_echo_valid        (o_echo_valid),
    .o_wake_readers      (o_wake_readers),
    .o_read_char         (o_read_char),
    .o_line_end          (o_line_end)
);
